// File: design/kclr_pkg.sv
// shared types, codes and constants of the key combo level repeater
`default_nettype none

package kclr_pkg;

  localparam int unsigned CodeW    = 10;
  localparam int unsigned AltW     = 20;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned VolOutW  = 5;
  localparam int unsigned BriOutW  = 4;

  // request kinds
  localparam logic [1:0] ReqFrameStart = 2'd0;
  localparam logic [1:0] ReqKey        = 2'd1;
  localparam logic [1:0] ReqFrameEnd   = 2'd2;
  localparam logic [1:0] ReqLoad       = 2'd3;

  // device modes, the unused code behaves as the menu mode
  localparam logic [1:0] ModeMenu     = 2'd0;
  localparam logic [1:0] ModeCombo    = 2'd1;
  localparam logic [1:0] ModeShoulder = 2'd2;

  // key values
  localparam logic [1:0] KeyRelease = 2'd0;
  localparam logic [1:0] KeyOther   = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDeviceMode = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgMenuCode   = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgStartCode  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgSelectCode = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgPlusCode   = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgMinusCode  = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgUpAlt      = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgDownAlt    = 4'd7;

  // register reset values
  localparam logic [1:0]       RstDeviceMode = ModeMenu;
  localparam logic [CodeW-1:0] RstMenuCode   = 10'd708;
  localparam logic [CodeW-1:0] RstStartCode  = 10'd705;
  localparam logic [CodeW-1:0] RstSelectCode = 10'd704;
  localparam logic [CodeW-1:0] RstPlusCode   = 10'd115;
  localparam logic [CodeW-1:0] RstMinusCode  = 10'd114;
  localparam logic [AltW-1:0]  RstUpAlt      = 20'd320823;
  localparam logic [AltW-1:0]  RstDownAlt    = 20'd319798;

  // timing in ms
  localparam logic [TimeW-1:0] FirstDelayMs = 32'd300;
  localparam logic [TimeW-1:0] NextDelayMs  = 32'd100;
  localparam logic [TimeW-1:0] GapMs        = 32'd1000;

  typedef struct packed {
    logic [1:0]       device_mode;
    logic [CodeW-1:0] menu_code;
    logic [CodeW-1:0] start_code;
    logic [CodeW-1:0] select_code;
    logic [CodeW-1:0] plus_code;
    logic [CodeW-1:0] minus_code;
    logic [AltW-1:0]  up_alt_codes;
    logic [AltW-1:0]  down_alt_codes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [TimeW-1:0]   now_ms;
    logic               is_key;
    logic [CodeW-1:0]   key_code;
    logic [1:0]         key_value;
    logic [VolOutW-1:0] load_volume;
    logic [BriOutW-1:0] load_brightness;
  } in_item_t;

  typedef struct packed {
    logic [VolOutW-1:0] volume_level;
    logic [BriOutW-1:0] brightness_level;
    logic               volume_changed;
    logic               brightness_changed;
    logic               kill_combo;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/kclr_cfg.sv
// configuration register file
`default_nettype none

module kclr_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kclr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [kclr_pkg::CfgDataW-1:0] cfg_data_i,
  output kclr_pkg::cfg_t                     cfg_o
);
  import kclr_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (cfg_index_i)
        CfgDeviceMode: cfg_d.device_mode    = cfg_data_i[1:0];
        CfgMenuCode:   cfg_d.menu_code      = cfg_data_i[CodeW-1:0];
        CfgStartCode:  cfg_d.start_code     = cfg_data_i[CodeW-1:0];
        CfgSelectCode: cfg_d.select_code    = cfg_data_i[CodeW-1:0];
        CfgPlusCode:   cfg_d.plus_code      = cfg_data_i[CodeW-1:0];
        CfgMinusCode:  cfg_d.minus_code     = cfg_data_i[CodeW-1:0];
        CfgUpAlt:      cfg_d.up_alt_codes   = cfg_data_i[AltW-1:0];
        CfgDownAlt:    cfg_d.down_alt_codes = cfg_data_i[AltW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_mode    <= RstDeviceMode;
      cfg_q.menu_code      <= RstMenuCode;
      cfg_q.start_code     <= RstStartCode;
      cfg_q.select_code    <= RstSelectCode;
      cfg_q.plus_code      <= RstPlusCode;
      cfg_q.minus_code     <= RstMinusCode;
      cfg_q.up_alt_codes   <= RstUpAlt;
      cfg_q.down_alt_codes <= RstDownAlt;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/kclr_step.sv
// key and level state with the single pass step logic
`default_nettype none

module kclr_step #(
  parameter int unsigned VOLUME_TOP     = 20,
  parameter int unsigned BRIGHTNESS_TOP = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire kclr_pkg::in_item_t  item_i,
  input  wire kclr_pkg::cfg_t      cfg_i,
  output kclr_pkg::out_item_t      res_o
);
  import kclr_pkg::*;

  localparam int unsigned VolW = $clog2(VOLUME_TOP + 1);
  localparam int unsigned BriW = $clog2(BRIGHTNESS_TOP + 1);
  localparam logic [VolW-1:0] VolTop = VolW'(VOLUME_TOP);
  localparam logic [BriW-1:0] BriTop = BriW'(BRIGHTNESS_TOP);

  logic [TimeW-1:0] ft_q, ft_d, prev_q, prev_d, up_due_q, up_due_d, dn_due_q, dn_due_d;
  logic             first_q, first_d, ign_q, ign_d;
  logic             menu_q, menu_d, start_q, start_d, sel_q, sel_d;
  logic             up_held_q, up_held_d, up_fresh_q, up_fresh_d;
  logic             dn_held_q, dn_held_d, dn_fresh_q, dn_fresh_d;
  logic [VolW-1:0]  vol_q, vol_d;
  logic [BriW-1:0]  bri_q, bri_d;

  logic             kv, alt, up_hit, dn_hit, to_bri, to_vol, up_go, dn_go, kill;

  function automatic logic [VolW-1:0] move_vol(input logic [VolW-1:0] l, input logic up);
    logic [VolW-1:0] r;
    r = l;
    if (up) begin
      if (l < VolTop) r = l + VolW'(1);
    end else if (l != '0) begin
      r = l - VolW'(1);
    end
    return r;
  endfunction

  function automatic logic [BriW-1:0] move_bri(input logic [BriW-1:0] l, input logic up);
    logic [BriW-1:0] r;
    r = l;
    if (up) begin
      if (l < BriTop) r = l + BriW'(1);
    end else if (l != '0) begin
      r = l - BriW'(1);
    end
    return r;
  endfunction

  // level routing from the held modifiers
  always_comb begin
    if (cfg_i.device_mode == ModeShoulder) begin
      to_vol = sel_q;
      to_bri = !sel_q && start_q;
    end else begin
      to_bri = menu_q || (cfg_i.device_mode == ModeCombo && sel_q && start_q);
      to_vol = !to_bri;
    end
  end

  assign kv     = item_i.key_value != KeyRelease;
  assign alt    = cfg_i.device_mode == ModeShoulder;
  assign up_hit = (item_i.key_code == cfg_i.plus_code) ||
                  (alt && (item_i.key_code == cfg_i.up_alt_codes[CodeW-1:0] ||
                           item_i.key_code == cfg_i.up_alt_codes[AltW-1:CodeW]));
  assign dn_hit = (item_i.key_code == cfg_i.minus_code) ||
                  (alt && (item_i.key_code == cfg_i.down_alt_codes[CodeW-1:0] ||
                           item_i.key_code == cfg_i.down_alt_codes[AltW-1:CodeW]));

  always_comb begin
    ft_d       = ft_q;
    prev_d     = prev_q;
    first_d    = first_q;
    ign_d      = ign_q;
    menu_d     = menu_q;
    start_d    = start_q;
    sel_d      = sel_q;
    up_held_d  = up_held_q;
    up_fresh_d = up_fresh_q;
    up_due_d   = up_due_q;
    dn_held_d  = dn_held_q;
    dn_fresh_d = dn_fresh_q;
    dn_due_d   = dn_due_q;
    vol_d      = vol_q;
    bri_d      = bri_q;
    kill       = 1'b0;
    up_go      = 1'b0;
    dn_go      = 1'b0;
    unique case (item_i.req_type)
      ReqFrameStart: begin
        ft_d  = item_i.now_ms;
        ign_d = !first_q && ((item_i.now_ms - prev_q) > GapMs);
      end
      ReqKey: begin
        if (!ign_q && item_i.is_key && item_i.key_value != KeyOther) begin
          if (item_i.key_code == cfg_i.menu_code)   menu_d  = kv;
          if (item_i.key_code == cfg_i.select_code) sel_d   = kv;
          if (item_i.key_code == cfg_i.start_code)  start_d = kv;
          if (up_hit) begin
            up_held_d  = kv;
            up_fresh_d = kv;
            if (kv) up_due_d = ft_q + FirstDelayMs;
          end
          if (dn_hit) begin
            dn_held_d  = kv;
            dn_fresh_d = kv;
            if (kv) dn_due_d = ft_q + FirstDelayMs;
          end
        end
      end
      ReqFrameEnd: begin
        // a dropped frame releases menu, up and down but not start or select
        if (ign_q) begin
          menu_d     = 1'b0;
          up_held_d  = 1'b0;
          up_fresh_d = 1'b0;
          up_due_d   = '0;
          dn_held_d  = 1'b0;
          dn_fresh_d = 1'b0;
          dn_due_d   = '0;
        end
        kill  = start_q && sel_q;
        up_go = up_fresh_d || (up_held_d && ft_q >= up_due_d);
        if (up_go) begin
          if (to_vol) vol_d = move_vol(vol_d, 1'b1);
          if (to_bri) bri_d = move_bri(bri_d, 1'b1);
          if (up_fresh_d) up_fresh_d = 1'b0;
          else            up_due_d   = up_due_d + NextDelayMs;
        end
        dn_go = dn_fresh_d || (dn_held_d && ft_q >= dn_due_d);
        if (dn_go) begin
          if (to_vol) vol_d = move_vol(vol_d, 1'b0);
          if (to_bri) bri_d = move_bri(bri_d, 1'b0);
          if (dn_fresh_d) dn_fresh_d = 1'b0;
          else            dn_due_d   = dn_due_d + NextDelayMs;
        end
        prev_d  = ft_q;
        ign_d   = 1'b0;
        first_d = 1'b0;
      end
      ReqLoad: begin
        vol_d = (32'(item_i.load_volume) > 32'(VOLUME_TOP)) ? VolTop :
                VolW'(item_i.load_volume);
        bri_d = (32'(item_i.load_brightness) > 32'(BRIGHTNESS_TOP)) ? BriTop :
                BriW'(item_i.load_brightness);
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.volume_level       = VolOutW'(vol_d);
    res_o.brightness_level   = BriOutW'(bri_d);
    res_o.volume_changed     = vol_d != vol_q;
    res_o.brightness_changed = bri_d != bri_q;
    res_o.kill_combo         = kill;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q       <= '0;
      prev_q     <= '0;
      first_q    <= 1'b1;
      ign_q      <= 1'b0;
      menu_q     <= 1'b0;
      start_q    <= 1'b0;
      sel_q      <= 1'b0;
      up_held_q  <= 1'b0;
      up_fresh_q <= 1'b0;
      up_due_q   <= '0;
      dn_held_q  <= 1'b0;
      dn_fresh_q <= 1'b0;
      dn_due_q   <= '0;
      vol_q      <= '0;
      bri_q      <= '0;
    end else if (fire_i) begin
      ft_q       <= ft_d;
      prev_q     <= prev_d;
      first_q    <= first_d;
      ign_q      <= ign_d;
      menu_q     <= menu_d;
      start_q    <= start_d;
      sel_q      <= sel_d;
      up_held_q  <= up_held_d;
      up_fresh_q <= up_fresh_d;
      up_due_q   <= up_due_d;
      dn_held_q  <= dn_held_d;
      dn_fresh_q <= dn_fresh_d;
      dn_due_q   <= dn_due_d;
      vol_q      <= vol_d;
      bri_q      <= bri_d;
    end
  end

endmodule

`default_nettype wire

// File: design/key_combo_level_repeater.sv
// top level of the key combo level repeater
// flow: a beat accepted into the input register moves into the result register once
//   the result register is empty or drained, so a stalled result holds it back
// throughput: one beat per cycle while the result side does not stall, set by the
//   single pass step logic between the input register and the result register
// reset: asynchronous active low; clears the pipeline valids, the key and level
//   state and loads the register defaults, no clearing sweep
`default_nettype none

module key_combo_level_repeater #(
  parameter int unsigned VOLUME_TOP     = 20,
  parameter int unsigned BRIGHTNESS_TOP = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire kclr_pkg::in_item_t            in_item_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output kclr_pkg::out_item_t                out_item_o,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kclr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [kclr_pkg::CfgDataW-1:0] cfg_data_i
);
  import kclr_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid_q;
  logic      advance;
  logic      fire;
  logic      load_in;

  // pipeline moves on whenever the result register is empty or being drained
  assign advance = !out_valid_q || !out_stall_i;
  // the step fires as the held beat moves into the result register
  assign fire    = in_valid_q && advance;
  // input register refills when it is empty or its beat moves on
  assign load_in = !in_valid_q || advance;
  // stall only when the input register holds a beat that cannot move
  assign in_stall_o = in_valid_q && !advance;

  kclr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kclr_step #(
    .VOLUME_TOP     (VOLUME_TOP),
    .BRIGHTNESS_TOP (BRIGHTNESS_TOP)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register, payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // result register, holds its beat while the far side stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: design/kclr_checker.sv
// port level checks of the key combo level repeater and their bind
`default_nettype none

module kclr_checker #(
  parameter int unsigned VOLUME_TOP     = 20,
  parameter int unsigned BRIGHTNESS_TOP = 10
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire kclr_pkg::in_item_t            in_item_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire kclr_pkg::out_item_t           out_item_o
);
  import kclr_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled input beat stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input beat changed while stalled");

  // levels never leave their range
  a_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_item_o.volume_level) <= 32'(VOLUME_TOP) &&
                     32'(out_item_o.brightness_level) <= 32'(BRIGHTNESS_TOP)))
    else $error("level beyond its top");

  // an empty result register never holds back the input side
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // an input beat taken with the output side free reaches the result port through the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result beat missing");

endmodule

bind key_combo_level_repeater kclr_checker #(
  .VOLUME_TOP     (VOLUME_TOP),
  .BRIGHTNESS_TOP (BRIGHTNESS_TOP)
) u_kclr_checker (.*);

`default_nettype wire
